FILE: sv/cht_pkg.sv
// ----------------------------------------------------------------------------
// cht_pkg
// Types and codes shared by the chained hash table and its checker.
// ----------------------------------------------------------------------------
package cht_pkg;

  localparam int KEY_W  = 8;
  localparam int REC_W  = 16;
  localparam int ACT_W  = 2;
  localparam int STAT_W = 2;
  localparam int BKT_W  = 4;
  localparam int TS_W   = 5;

  localparam logic [TS_W-1:0] TS_RESET = 5'd16;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FIND   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DELETE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [KEY_W-1:0] key;
    logic [REC_W-1:0] record;
  } cht_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [REC_W-1:0]  found_record;
    logic [BKT_W-1:0]  bucket;
  } cht_rsp_t;

endpackage

FILE: sv/cht_ram.sv
// ----------------------------------------------------------------------------
// cht_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cht_ram #(
  parameter int WIDTH = 8,
  parameter int WORDS = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(WORDS > 1 ? $clog2(WORDS) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(WORDS > 1 ? $clog2(WORDS) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/chained_hash_table.sv
// ----------------------------------------------------------------------------
// chained_hash_table
// Hash table with separate chaining, bucket = key mod table_size.
//
// Request channel (req_valid/req_ready/req) takes insert, find or delete
// items; every item gives exactly one response item on rsp_valid/rsp_ready/rsp.
// The cfg channel writes table_size (clamped to 1..BUCKETS); write it only
// while no item is in flight. cfg_ready is always high.
// Steps per item: the key mod, a radix-2 restoring loop at one bit per
// cycle; a read of the bucket's fill count; for find and delete, a scan of
// the bucket's entries, and for delete on a hit a shift-down of the later
// entries. Scan and shift go one entry at a time through the entry RAM's
// single read port, a read state then a compare or write state per entry.
// One item at a time: req_ready is low while busy and rises again when
// the response is loaded into the output register.
// A finished response sits in an output register, so a new item is taken
// while the previous response waits for rsp_ready; the next response then
// holds inside the block until that register frees.
// Reset (synchronous) empties all buckets through per-bucket valid bits
// and sets table_size to 16; no clearing pass is needed.
// ----------------------------------------------------------------------------
module chained_hash_table
  import cht_pkg::*;
#(
  parameter int BUCKETS = 16,
  parameter int DEPTH   = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  cht_req_t        req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output cht_rsp_t        rsp,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [TS_W-1:0] cfg_data
);

  localparam int BIW     = BUCKETS > 1 ? $clog2(BUCKETS) : 1;
  localparam int ENTRIES = BUCKETS * DEPTH;
  localparam int AW      = ENTRIES > 1 ? $clog2(ENTRIES) : 1;
  localparam int FW      = $clog2(DEPTH + 1);
  localparam int EW      = KEY_W + REC_W;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_FILL_RD, S_FILL, S_SCAN_RD, S_SCAN,
    S_SHIFT_RD, S_SHIFT_WR, S_DEL_END, S_DONE
  } state_t;

  state_t             state;
  logic [TS_W-1:0]    table_size;
  logic [TS_W-1:0]    eff;
  logic [TS_W-1:0]    eff_r;
  logic [TS_W-1:0]    rem;
  logic [TS_W-1:0]    rem_next;
  logic [TS_W:0]      trial;
  logic [2:0]         bit_cnt;
  logic [ACT_W-1:0]   action_r;
  logic [KEY_W-1:0]   key_r;
  logic [REC_W-1:0]   record_r;
  logic [STAT_W-1:0]  status_r;
  logic [REC_W-1:0]   found_r;
  logic [AW-1:0]      base;
  logic [FW-1:0]      idx;
  logic [FW-1:0]      n;
  logic [FW-1:0]      n_cur;
  logic [BUCKETS-1:0] fill_valid;
  logic [BIW-1:0]     bidx;

  logic               ent_we;
  logic [AW-1:0]      ent_waddr;
  logic [EW-1:0]      ent_wdata;
  logic [AW-1:0]      ent_raddr;
  logic [EW-1:0]      ent_q;
  logic               fill_we;
  logic [FW-1:0]      fill_wdata;
  logic [FW-1:0]      fill_q;
  logic               key_hit;
  logic               more1;
  logic               more2;

  assign cfg_ready = 1'b1;
  assign req_ready = (state == S_IDLE);

  always_comb begin
    eff = table_size;
    if (table_size == '0) begin
      eff = TS_W'(1);
    end else if (int'(table_size) > BUCKETS) begin
      eff = TS_W'(BUCKETS);
    end
  end

  assign trial    = {rem, key_r[bit_cnt]};
  assign rem_next = (trial >= {1'b0, eff_r}) ? TS_W'(trial - {1'b0, eff_r}) : trial[TS_W-1:0];
  assign bidx     = BIW'(rem);
  assign n_cur    = fill_valid[bidx] ? fill_q : '0;
  assign key_hit  = (ent_q[EW-1:REC_W] == key_r);
  assign more1    = ({1'b0, idx} + 1'b1) < {1'b0, n};
  assign more2    = ({1'b0, idx} + (FW+1)'(2)) < {1'b0, n};

  always_comb begin
    ent_we     = 1'b0;
    ent_waddr  = base + AW'(n_cur);
    ent_wdata  = {key_r, record_r};
    ent_raddr  = base + AW'(idx);
    fill_we    = 1'b0;
    fill_wdata = n_cur + 1'b1;
    case (state)
      S_FILL: begin
        if (action_r == ACT_INSERT && n_cur < FW'(DEPTH)) begin
          ent_we  = 1'b1;
          fill_we = 1'b1;
        end
      end
      S_SHIFT_RD: begin
        ent_raddr = base + AW'(idx) + 1'b1;
      end
      S_SHIFT_WR: begin
        ent_we    = 1'b1;
        ent_waddr = base + AW'(idx);
        ent_wdata = ent_q;
      end
      S_DEL_END: begin
        fill_we    = 1'b1;
        fill_wdata = n - 1'b1;
      end
      default: begin
      end
    endcase
  end

  cht_ram #(.WIDTH(EW), .WORDS(ENTRIES)) u_entries (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_q)
  );

  cht_ram #(.WIDTH(FW), .WORDS(BUCKETS)) u_fill (
    .clk   (clk),
    .we    (fill_we),
    .waddr (bidx),
    .wdata (fill_wdata),
    .raddr (bidx),
    .rdata (fill_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      table_size <= TS_RESET;
      fill_valid <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        table_size <= cfg_data;
      end
      if (fill_we) begin
        fill_valid[bidx] <= 1'b1;
      end
      if (rsp_valid && rsp_ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            action_r <= req.action;
            key_r    <= req.key;
            record_r <= req.record;
            eff_r    <= eff;
            rem      <= '0;
            bit_cnt  <= 3'd7;
            status_r <= ST_MISS;
            found_r  <= '0;
            idx      <= '0;
            state    <= S_DIV;
          end
        end
        S_DIV: begin
          rem     <= rem_next;
          bit_cnt <= bit_cnt - 1'b1;
          if (bit_cnt == 3'd0) begin
            state <= S_FILL_RD;
          end
        end
        S_FILL_RD: begin
          base  <= AW'(bidx * DEPTH);
          state <= S_FILL;
        end
        S_FILL: begin
          n <= n_cur;
          case (action_r)
            ACT_INSERT: begin
              status_r <= (n_cur < FW'(DEPTH)) ? ST_OK : ST_FULL;
              state    <= S_DONE;
            end
            ACT_FIND, ACT_DELETE: begin
              state <= (n_cur == '0) ? S_DONE : S_SCAN_RD;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_SCAN_RD: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (key_hit) begin
            status_r <= ST_OK;
            found_r  <= ent_q[REC_W-1:0];
            if (action_r == ACT_FIND) begin
              state <= S_DONE;
            end else begin
              state <= more1 ? S_SHIFT_RD : S_DEL_END;
            end
          end else if (more1) begin
            idx   <= idx + 1'b1;
            state <= S_SCAN_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_SHIFT_RD: begin
          state <= S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          idx   <= idx + 1'b1;
          state <= more2 ? S_SHIFT_RD : S_DEL_END;
        end
        S_DEL_END: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid        <= 1'b1;
            rsp.status       <= status_r;
            rsp.found_record <= found_r;
            rsp.bucket       <= rem[BKT_W-1:0];
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/cht_checker.sv
// ----------------------------------------------------------------------------
// cht_checker
// Port-level checks for the chained hash table, bound to the top level.
// ----------------------------------------------------------------------------
module cht_checker
  import cht_pkg::*;
(
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_ready,
  input logic            rsp_valid,
  input logic            rsp_ready,
  input cht_rsp_t        rsp
);

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("req_ready high right after an accepted item");

  // the mod loop always lies between an accept and its response
  a_no_instant_rsp: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> !$past(req_valid && req_ready))
    else $error("response one cycle after accept");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status == ST_OK || rsp.status == ST_MISS || rsp.status == ST_FULL))
    else $error("unknown status code");

  a_record_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != ST_OK) |-> (rsp.found_record == '0))
    else $error("record handle on a miss or full response");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled response changed");

endmodule

bind chained_hash_table cht_checker u_cht_checker (.*);
